/* design/rar_pkg.sv */
// Package with the shared widths and the divider command and response types.
`default_nettype none
package rar_pkg;
    localparam int IN_WIDTH = 32;
    localparam int WW       = 64;
    localparam int DEN_W    = 62;
    localparam int CNT_W    = 7;

    // Commands to the shared divider unit.
    typedef struct packed {
        logic          start;
        logic [WW-1:0] dividend;
        logic [WW-1:0] divisor;
    } t_div_cmd;

    typedef struct packed {
        logic          done;
        logic [WW-1:0] quot;
        logic [WW-1:0] rem;
    } t_div_rsp;
endpackage
`default_nettype wire

/* design/rational_add_reduce_core.sv */
// Top level: sequencer that adds two fractions and reduces them on a shared divider.
//
//  Channel | Direction | Handshake          | Payload
//  input   | in        | i_valid / o_stall  | i_a_num i_a_den i_b_num i_b_den
//  output  | out       | o_valid / i_stall  | o_sum_num o_sum_den o_den_fixed
//
// A divider pass starts the divider and waits until its result is taken. A gcd
// costs one pass per Euclid step and each non-zero fraction needs two more for the
// quotients; a zero numerator skips its gcd and quotients.
// Reset is synchronous and clears the sequencer. While an item is in work or its
// result waits, o_stall is high; the result holds while i_stall is high.
`default_nettype none
module rational_add_reduce_core
    import rar_pkg::*;
(
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic                i_valid,
    output logic                     o_stall,
    input  wire logic [IN_WIDTH-1:0] i_a_num,
    input  wire logic [IN_WIDTH-1:0] i_a_den,
    input  wire logic [IN_WIDTH-1:0] i_b_num,
    input  wire logic [IN_WIDTH-1:0] i_b_den,
    output logic                     o_valid,
    input  wire logic                i_stall,
    output logic [WW-1:0]            o_sum_num,
    output logic [DEN_W-1:0]         o_sum_den,
    output logic                     o_den_fixed
);
    localparam logic [3:0] S_IDLE = 4'd0, S_GCD = 4'd1, S_GWAIT = 4'd2,
        S_QN = 4'd3, S_QNW = 4'd4, S_QD = 4'd5, S_QDW = 4'd6,
        S_MUL1 = 4'd7, S_MUL2 = 4'd8, S_ADD = 4'd9, S_OUT = 4'd10;

    logic [3:0] r_st, n_st;
    logic r_ph, n_ph;            // 0: reducing a then b, 1: reducing the sum
    logic r_sel, n_sel;          // which input fraction
    logic [WW-1:0] r_x, n_x, r_y, n_y;
    logic [WW-1:0] r_an, n_an, r_ad, n_ad, r_bn, n_bn, r_bd, n_bd;
    logic [WW-1:0] r_t1, n_t1, r_t2, n_t2;
    logic r_aneg, n_aneg, r_bneg, n_bneg, r_sneg, n_sneg, r_fix, n_fix;
    logic [IN_WIDTH-1:0] w_an_m, w_ad_m, w_bn_m, w_bd_m;
    logic [WW-1:0] w_mul_a, w_mul_b, w_prod;
    t_div_cmd w_cmd;
    t_div_rsp w_rsp;

    function automatic logic [IN_WIDTH-1:0] mag(input logic [IN_WIDTH-1:0] v);
        mag = v[IN_WIDTH-1] ? (~v + 1'b1) : v;
    endfunction

    rar_div u_div (.i_clk(i_clk), .i_rst_n(i_rst_n), .i_cmd(w_cmd), .o_rsp(w_rsp));

    assign w_an_m = mag(i_a_num);
    assign w_ad_m = mag(i_a_den);
    assign w_bn_m = mag(i_b_num);
    assign w_bd_m = mag(i_b_den);

    // One 32x32 multiplier, shared by the three products.
    assign w_prod = w_mul_a[31:0] * w_mul_b[31:0];

    always_comb begin
        n_st = r_st; n_ph = r_ph; n_sel = r_sel; n_x = r_x; n_y = r_y;
        n_an = r_an; n_ad = r_ad; n_bn = r_bn; n_bd = r_bd; n_t1 = r_t1; n_t2 = r_t2;
        n_aneg = r_aneg; n_bneg = r_bneg; n_sneg = r_sneg; n_fix = r_fix;
        w_cmd = '{start: 1'b0, dividend: r_x, divisor: r_y};
        w_mul_a = r_an; w_mul_b = r_bd;
        case (r_st)
            S_IDLE: begin
                if (i_valid) begin
                    n_an = WW'(w_an_m); n_bn = WW'(w_bn_m);
                    n_ad = (w_ad_m == '0) ? WW'(1) : WW'(w_ad_m);
                    n_bd = (w_bd_m == '0) ? WW'(1) : WW'(w_bd_m);
                    n_fix = (w_ad_m == '0) || (w_bd_m == '0);
                    n_aneg = i_a_num[IN_WIDTH-1] ^ (i_a_den[IN_WIDTH-1] && w_ad_m != '0);
                    n_bneg = i_b_num[IN_WIDTH-1] ^ (i_b_den[IN_WIDTH-1] && w_bd_m != '0);
                    n_ph = 1'b0; n_sel = 1'b0;
                    n_x = WW'(w_an_m);
                    n_y = (w_ad_m == '0) ? WW'(1) : WW'(w_ad_m);
                    n_st = S_GCD;
                end
            end
            // Euclid: x, y hold the pair; zero numerator short-cuts to 0/1.
            S_GCD: begin
                if (r_x == '0) begin
                    // numerator zero: fraction is 0/1, positive
                    if (r_ph) begin
                        n_t1 = '0; n_t2 = WW'(1); n_sneg = 1'b0; n_st = S_OUT;
                    end else if (!r_sel) begin
                        n_an = '0; n_ad = WW'(1); n_aneg = 1'b0;
                        n_sel = 1'b1; n_x = r_bn; n_y = r_bd;
                    end else begin
                        n_bn = '0; n_bd = WW'(1); n_bneg = 1'b0; n_st = S_MUL1;
                    end
                end else if (r_y == '0) begin
                    n_x = r_ph ? r_t1 : (r_sel ? r_bn : r_an);
                    n_y = r_x;
                    n_st = S_QN;
                end else begin
                    w_cmd.start = 1'b1; n_st = S_GWAIT;
                end
            end
            S_GWAIT: if (w_rsp.done) begin
                n_x = r_y; n_y = w_rsp.rem; n_st = S_GCD;
            end
            S_QN: begin w_cmd.start = 1'b1; n_st = S_QNW; end
            S_QNW: if (w_rsp.done) begin
                if (r_ph) n_t1 = w_rsp.quot;
                else if (r_sel) n_bn = w_rsp.quot;
                else n_an = w_rsp.quot;
                n_x = r_ph ? r_t2 : (r_sel ? r_bd : r_ad);
                n_st = S_QD;
            end
            S_QD: begin w_cmd.start = 1'b1; n_st = S_QDW; end
            S_QDW: if (w_rsp.done) begin
                if (r_ph) begin
                    n_t2 = w_rsp.quot; n_st = S_OUT;
                end else if (r_sel) begin
                    n_bd = w_rsp.quot; n_st = S_MUL1;
                end else begin
                    n_ad = w_rsp.quot; n_sel = 1'b1;
                    n_x = r_bn; n_y = r_bd; n_st = S_GCD;
                end
            end
            S_MUL1: begin
                w_mul_a = r_an; w_mul_b = r_bd; n_t1 = w_prod; n_st = S_MUL2;
            end
            S_MUL2: begin
                w_mul_a = r_bn; w_mul_b = r_ad; n_t2 = w_prod; n_st = S_ADD;
            end
            // Signed add of the magnitudes, together with the denominator product.
            S_ADD: begin
                w_mul_a = r_ad; w_mul_b = r_bd;
                if (r_aneg == r_bneg) begin
                    n_t1 = r_t1 + r_t2; n_sneg = r_aneg;
                end else if (r_t1 >= r_t2) begin
                    n_t1 = r_t1 - r_t2; n_sneg = r_aneg;
                end else begin
                    n_t1 = r_t2 - r_t1; n_sneg = r_bneg;
                end
                n_t2 = w_prod;
                n_x = n_t1; n_y = w_prod;
                n_ph = 1'b1; n_sel = 1'b0;
                n_st = S_GCD;
            end
            S_OUT: if (!i_stall) n_st = S_IDLE;
            default: n_st = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_ph <= n_ph; r_sel <= n_sel; r_x <= n_x; r_y <= n_y;
        r_an <= n_an; r_ad <= n_ad; r_bn <= n_bn; r_bd <= n_bd;
        r_t1 <= n_t1; r_t2 <= n_t2; r_aneg <= n_aneg; r_bneg <= n_bneg;
        r_sneg <= n_sneg; r_fix <= n_fix;
        if (!i_rst_n) r_st <= S_IDLE;
        else r_st <= n_st;
    end

    assign o_stall     = (r_st != S_IDLE);
    assign o_valid     = (r_st == S_OUT);
    assign o_sum_num   = r_sneg ? (~r_t1 + 1'b1) : r_t1;
    assign o_sum_den   = r_t2[DEN_W-1:0];
    assign o_den_fixed = r_fix;

`ifndef SYNTHESIS
    a_out_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && i_stall) |=> (o_valid && $stable(o_sum_num))) else $error("result moved");
    a_den_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_sum_den != '0)) else $error("zero denominator");
    a_zero_pos: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && r_t1 == '0) |-> (o_sum_den == DEN_W'(1))) else $error("zero not 0/1");
`endif
endmodule
`default_nettype wire

/* design/rar_div.sv */
// Shared restoring divider, one quotient bit a cycle.
`default_nettype none
module rar_div
    import rar_pkg::*;
(
    input  wire logic     i_clk,
    input  wire logic     i_rst_n,
    input  wire t_div_cmd i_cmd,
    output t_div_rsp      o_rsp
);
    logic [WW-1:0] r_q, n_q, r_r, n_r, r_d, n_d;
    logic [CNT_W-1:0] r_cnt, n_cnt;
    logic r_busy, n_busy, r_done, n_done;
    logic [WW:0] w_trial;

    // One shift-and-subtract step per cycle.
    always_comb begin
        n_q = r_q; n_r = r_r; n_d = r_d; n_cnt = r_cnt;
        n_busy = r_busy; n_done = 1'b0;
        w_trial = {r_r, r_q[WW-1]} - {1'b0, r_d};
        if (i_cmd.start) begin
            n_q = i_cmd.dividend; n_r = '0; n_d = i_cmd.divisor;
            n_cnt = '0; n_busy = 1'b1;
        end else if (r_busy) begin
            if (!w_trial[WW]) begin
                n_r = w_trial[WW-1:0];
                n_q = {r_q[WW-2:0], 1'b1};
            end else begin
                n_r = {r_r[WW-2:0], r_q[WW-1]};
                n_q = {r_q[WW-2:0], 1'b0};
            end
            n_cnt = r_cnt + 1'b1;
            if (r_cnt == CNT_W'(WW-1)) begin
                n_busy = 1'b0; n_done = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_q <= n_q; r_r <= n_r; r_d <= n_d; r_cnt <= n_cnt;
        if (!i_rst_n) begin
            r_busy <= 1'b0; r_done <= 1'b0;
        end else begin
            r_busy <= n_busy; r_done <= n_done;
        end
    end

    assign o_rsp = '{done: r_done, quot: r_q, rem: r_r};

`ifndef SYNTHESIS
    a_done_after_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_done |-> $past(r_busy)) else $error("done without busy");
    a_no_done_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.start |=> !r_done) else $error("done right after start");
    a_rem_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_done && r_d != '0) |-> (r_r < r_d)) else $error("remainder too big");
`endif
endmodule
`default_nettype wire
